>>> rtl/sdfir_pkg.sv
package sdfir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MASK_W   = 16;
  localparam int INDEX_W  = 8;
  localparam int COEF_W   = MASK_W + 1;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 40;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [ACC_W-1:0]           acc_t;

  // Cell row control: shift pushes a new sample in, rotate walks the ring.
  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  // Signed value of a digit word: positive digits minus negative digits.
  // A sign bit without its digit bit contributes nothing.
  function automatic coef_t coef_value(logic [MASK_W-1:0] digits,
                                       logic [MASK_W-1:0] negs);
    logic [MASK_W-1:0] pos_bits;
    logic [MASK_W-1:0] neg_bits;
    pos_bits = digits & ~negs;
    neg_bits = digits & negs;
    coef_value = $signed({1'b0, pos_bits}) - $signed({1'b0, neg_bits});
  endfunction

endpackage

>>> rtl/signed_digit_fir_filter_core.sv
// Signed-digit FIR filter, TAPS taps. Each tap is a cell holding one delay-line
// sample and the signed value of its coefficient word. A coefficient write item
// (command = 1) gives no result; tap indexes at or above TAPS are dropped. A
// sample item (command = 0) pushes the sample into the delay line, then the
// cell row rotates as a ring, passing each tap pair through one shared
// multiply-accumulate unit at cell 0; the ring is back in its original order
// when the pass ends. The product and its valid flag are registered ahead of
// the accumulator, and the sequencer steps through its run, drain and done
// states before the result is loaded into the output register; the next item
// is accepted only once that result has moved into the output register, which
// waits while an earlier result is still held there. The output register
// holds the result until taken, and the next item is accepted while it waits.
// The result is the low 40 bits of the two's complement tap sum.
module signed_digit_fir_filter_core #(
  parameter int TAPS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [sdfir_pkg::SAMPLE_W-1:0] sample,
  input  logic [sdfir_pkg::INDEX_W-1:0]       tap_index,
  input  logic [sdfir_pkg::MASK_W-1:0]        digit_mask,
  input  logic [sdfir_pkg::MASK_W-1:0]        negative_mask,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sdfir_pkg::ACC_W-1:0]         filtered
);
  import sdfir_pkg::*;

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             do_filter;
  logic             do_write;
  logic             load_out;
  cell_ctrl_t       ctrl;
  coef_t            wr_coef;
  acc_t             acc;
  acc_t             out_data;

  sample_t cell_sample [TAPS];
  coef_t   cell_coef   [TAPS];

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign do_filter = accept && (command == CMD_FILTER);
  assign do_write  = accept && (command == CMD_WRITE);
  assign wr_coef   = coef_value(digit_mask, negative_mask);

  assign ctrl.shift  = do_filter;
  assign ctrl.rotate = (state == ST_RUN);

  // Hand the result over only when the output register is free.
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (do_filter) state_next = ST_RUN;
      ST_RUN:   if (cnt == CNT_W'(TAPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (do_filter) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Cell row: cell 0 takes the new sample on a shift and the last cell on a
  // rotate, so the ring closes through cell 0.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    sample_t prev_sample;
    coef_t   prev_coef;
    logic    wr_en;

    if (k == 0) begin : g_head
      assign prev_sample = ctrl.shift ? sample : cell_sample[TAPS-1];
      assign prev_coef   = cell_coef[TAPS-1];
    end else begin : g_body
      assign prev_sample = cell_sample[k-1];
      assign prev_coef   = cell_coef[k-1];
    end

    // taps past the index range are never written
    assign wr_en = do_write && (32'(tap_index) == k);

    sdfir_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .wr_en       (wr_en),
      .wr_coef     (wr_coef),
      .prev_sample (prev_sample),
      .prev_coef   (prev_coef),
      .sample_q    (cell_sample[k]),
      .coef_q      (cell_coef[k])
    );
  end

  // Accumulate the pair sitting in cell 0 on every rotate cycle.
  sdfir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (do_filter),
    .en     (ctrl.rotate),
    .sample (cell_sample[0]),
    .coef   (cell_coef[0]),
    .acc    (acc)
  );

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= acc;
    end
  end

  assign filtered = out_data;

endmodule

>>> rtl/sdfir_cell.sv
module sdfir_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  sdfir_pkg::cell_ctrl_t ctrl,
  input  logic                 wr_en,
  input  sdfir_pkg::coef_t     wr_coef,
  input  sdfir_pkg::sample_t   prev_sample,
  input  sdfir_pkg::coef_t     prev_coef,
  output sdfir_pkg::sample_t   sample_q,
  output sdfir_pkg::coef_t     coef_q
);
  import sdfir_pkg::*;

  sample_t sample_r;
  coef_t   coef_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_r <= '0;
      coef_r   <= '0;
    end else begin
      if (wr_en) begin
        coef_r <= wr_coef;
      end
      if (ctrl.shift || ctrl.rotate) begin
        sample_r <= prev_sample;
      end
      if (ctrl.rotate) begin
        coef_r <= prev_coef;
      end
    end
  end

  assign sample_q = sample_r;
  assign coef_q   = coef_r;

endmodule

>>> rtl/sdfir_mac.sv
module sdfir_mac (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               en,
  input  sdfir_pkg::sample_t sample,
  input  sdfir_pkg::coef_t   coef,
  output sdfir_pkg::acc_t    acc
);
  import sdfir_pkg::*;

  prod_t prod;
  logic  prod_valid;
  acc_t  acc_r;

  always_ff @(posedge clk) begin
    prod <= prod_t'(sample) * prod_t'(coef);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prod_valid <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_valid <= en;
      if (prod_valid) begin
        // sign-extend the product, wrap modulo 2^ACC_W
        acc_r <= acc_r + acc_t'({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
      end
    end
  end

  assign acc = acc_r;

endmodule
